@@ hw/rtl/ascii_decimal_to_fixed_top_assert.svh @@
// Assertion macros for the ASCII decimal to fixed-point converter.
// Used by ascii_decimal_to_fixed_top; depends on nothing else.
`ifndef ASCII_DECIMAL_TO_FIXED_TOP_ASSERT_SVH
`define ASCII_DECIMAL_TO_FIXED_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define ADF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define ADF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ADF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ADF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/adf_pkg.sv @@
// Shared constants, types and functions of the ASCII decimal to fixed-point converter.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package adf_pkg;

	// Number format
	localparam int FRAC_BITS       = 16;
	localparam int MAX_FRAC_DIGITS = 9;

	// Field and accumulator widths
	localparam int CHAR_W = 8;
	localparam int INT_W  = 31;
	localparam int FRAC_W = 30;
	localparam int FCNT_W = 4;
	localparam int OUT_W  = 48;
	localparam int ST_W   = 2;
	localparam int MAG_W  = INT_W + FRAC_BITS;
	localparam int WIDE_W = (MAG_W > OUT_W) ? MAG_W : OUT_W;
	localparam int STEP_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

	localparam logic [INT_W-1:0]  INT_MAX_MAG = '1;
	localparam logic [OUT_W-2:0]  OUT_MAX_MAG = '1;
	localparam logic [FCNT_W-1:0] FRAC_CNT_MAX = FCNT_W'(MAX_FRAC_DIGITS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_BITS - 1);

	// Status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [ST_W-1:0] ST_INT_SAT  = 2'd2;
	localparam logic [ST_W-1:0] ST_FRAC_OVF = 2'd3;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// Commands from controller to datapath
	typedef struct packed {
		logic take_char;
		logic div_init;
		logic div_step;
		logic sum;
		logic load_out;
	} adf_cmd_t;

	// Power of ten for a fraction digit count; counts above nine clamp
	function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] cnt);
		logic [FRAC_W-1:0] p;
		unique case (cnt)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			default: p = 30'd1000000000;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/adf_char_if.sv @@
// Character input channel: valid/ready handshake with one character per item.
// Depends on adf_pkg.
`default_nettype none

interface adf_char_if import adf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/adf_result_if.sv @@
// Result output channel: valid/ready handshake with value and status per item.
// Depends on adf_pkg.
`default_nettype none

interface adf_result_if import adf_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] value;
	logic [ST_W-1:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ascii_decimal_to_fixed_top.sv @@
// ASCII decimal string to signed fixed-point converter (48 bits, FRAC_BITS fraction bits).
// Characters arrive one per item; an optional sign leads, digits, one point, fraction
// digits follow. Intake stays ready until the character marked last. After that
// character, the block stops taking characters while the fraction digits are
// divided by ten to the digit count in a restoring divider that yields one
// quotient bit a cycle, then the integer and fraction are joined and the sign
// applied. The result waits in an output register; if it has not been taken when
// the next result is ready, intake waits as well.
// Status reports the first error of the string: bad character or second point,
// integer saturation, or too many fraction digits.
// Depends on adf_pkg, adf_char_if, adf_result_if, adf_ctrl, adf_datapath.
`default_nettype none

`include "ascii_decimal_to_fixed_top_assert.svh"

module ascii_decimal_to_fixed_top import adf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	adf_char_if.sink     din,
	adf_result_if.source dout
);

	adf_cmd_t cmd;

	// Sequence the conversion
	adf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (din.valid),
		.in_is_last (din.is_last),
		.in_ready   (din.ready),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready),
		.cmd        (cmd)
	);

	// Accumulate, divide and form the result
	adf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.char_code (din.char_code),
		.value     (dout.value),
		.status    (dout.status)
	);

	`ADF_ASSERT_IMP(a_no_intake_in_div, clk, arst_n, cmd.div_step, !din.ready, "character taken while dividing")
	`ADF_ASSERT_NXT(a_last_stops_intake, clk, arst_n, din.valid && din.ready && din.is_last, !din.ready, "intake continues after last character")
	`ADF_ASSERT_NXT(a_load_shows_result, clk, arst_n, cmd.load_out, dout.valid, "loaded result not shown")
	`ADF_ASSERT_IMP(a_result_from_load, clk, arst_n, $rose(dout.valid), $past(cmd.load_out), "result shown without load")

endmodule

`default_nettype wire

@@ hw/rtl/adf_ctrl.sv @@
// Controller: sequences character intake, fraction division, sum and result hand-off.
// Depends on adf_pkg.
`default_nettype none

module adf_ctrl import adf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_is_last,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output adf_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_ACC,
		S_INIT,
		S_DIV,
		S_SUM,
		S_OUT
	} state_t;

	state_t            state_q;
	logic              ready_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign accept = in_valid && ready_q;

	// Decode datapath commands
	always_comb begin
		cmd.take_char = accept;
		cmd.div_init  = (state_q == S_INIT);
		cmd.div_step  = (state_q == S_DIV);
		cmd.sum       = (state_q == S_SUM);
		cmd.load_out  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	// Hold state, step counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			// Raise the result flag on load, drop it once the item is taken
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_ACC: begin
					if (accept && in_is_last) begin
						ready_q <= 1'b0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					step_q  <= STEP_LAST;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0)
						state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						ready_q <= 1'b1;
						state_q <= S_ACC;
					end
				end
				default: begin
					state_q <= S_ACC;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready  = ready_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/adf_datapath.sv @@
// Datapath: character accumulators, restoring divider for the fraction and result register.
// Depends on adf_pkg; driven by adf_ctrl commands.
`default_nettype none

module adf_datapath import adf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire adf_cmd_t          cmd,
	input  wire logic [CHAR_W-1:0] char_code,
	output logic signed [OUT_W-1:0] value,
	output logic [ST_W-1:0]        status
);

	// Accumulated string state
	logic [INT_W-1:0]  int_q;
	logic [FRAC_W-1:0] frac_q;
	logic [FCNT_W-1:0] fcnt_q;
	logic              point_q;
	logic              neg_q;
	logic              first_q;
	logic [ST_W-1:0]   err_q;

	// Divider and result registers
	logic [FRAC_W-1:0]    rem_q;
	logic [FRAC_W-1:0]    div_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [OUT_W-2:0]     mag_q;
	logic [OUT_W-1:0]     value_q;
	logic [ST_W-1:0]      status_q;

	logic              is_digit;
	logic              is_sign;
	logic [3:0]        digit;
	logic [INT_W+3:0]  int_next;
	logic              int_sat;
	logic [FRAC_W+3:0] frac_next;
	logic [FRAC_W:0]   rem_dbl;
	logic              rem_ge;
	logic [WIDE_W-1:0] mag_wide;
	logic              mag_sat;
	logic [OUT_W-1:0]  mag_ext;

	// Classify the character and form the next accumulator values
	always_comb begin
		is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		is_sign   = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		digit     = 4'(char_code - CH_ZERO);
		int_next  = ((INT_W+4)'(int_q) << 3) + ((INT_W+4)'(int_q) << 1) + (INT_W+4)'(digit);
		int_sat   = int_next > (INT_W+4)'(INT_MAX_MAG);
		frac_next = ((FRAC_W+4)'(frac_q) << 3) + ((FRAC_W+4)'(frac_q) << 1)
			+ (FRAC_W+4)'(digit);
	end

	// One restoring division step
	always_comb begin
		rem_dbl = {rem_q, 1'b0};
		rem_ge  = rem_dbl >= {1'b0, div_q};
	end

	// Join integer and fraction, clamp to the output range
	always_comb begin
		mag_wide = WIDE_W'({int_q, quo_q});
		mag_sat  = mag_wide > WIDE_W'(OUT_MAX_MAG);
		mag_ext  = {1'b0, mag_q};
	end

	// Accumulate characters; clear once the result is loaded into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q   <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			point_q <= 1'b0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			err_q   <= ST_OK;
		end else if (cmd.load_out) begin
			int_q   <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			point_q <= 1'b0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			err_q   <= ST_OK;
		end else if (cmd.take_char) begin
			first_q <= 1'b0;
			if (first_q && is_sign) begin
				neg_q <= (char_code == CH_MINUS);
			end else if (is_digit) begin
				if (!point_q) begin
					if (int_sat) begin
						int_q <= INT_MAX_MAG;
						if (err_q == ST_OK)
							err_q <= ST_INT_SAT;
					end else begin
						int_q <= int_next[INT_W-1:0];
					end
				end else if (fcnt_q < FRAC_CNT_MAX) begin
					frac_q <= frac_next[FRAC_W-1:0];
					fcnt_q <= fcnt_q + 1'b1;
				end else if (err_q == ST_OK) begin
					err_q <= ST_FRAC_OVF;
				end
			end else if (char_code == CH_POINT && !point_q) begin
				point_q <= 1'b1;
			end else if (err_q == ST_OK) begin
				err_q <= ST_BAD_CHAR;
			end
		end else if (cmd.sum && mag_sat && err_q == ST_OK) begin
			err_q <= ST_INT_SAT;
		end
	end

	// Divide the fraction digits by ten to the digit count, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= frac_q;
			div_q <= pow10(fcnt_q);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge)
				rem_q <= FRAC_W'(rem_dbl - {1'b0, div_q});
			else
				rem_q <= rem_dbl[FRAC_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
		end
	end

	// Form the magnitude, then apply the sign into the output register
	always_ff @(posedge clk) begin
		if (cmd.sum)
			mag_q <= mag_sat ? OUT_MAX_MAG : mag_wide[OUT_W-2:0];
		if (cmd.load_out) begin
			value_q  <= neg_q ? (OUT_W'(0) - mag_ext) : mag_ext;
			status_q <= err_q;
		end
	end

	assign value  = $signed(value_q);
	assign status = status_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for ascii_decimal_to_fixed_top: sends number strings one
// character per item and checks each fixed-point result and status against its own model.
// Depends on adf_pkg, adf_char_if, adf_result_if and the converter RTL.
`timescale 1ns / 1ps

module tb;
	import adf_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 3 * (FRAC_BITS + 3);
	localparam int TARGET_CHARS = 1700;
	localparam int RX_HOLD      = 400;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
		logic              drain;
	} char_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic [ST_W-1:0]         status;
	} fixed_result_t;

	logic clk;
	logic arst_n;

	adf_char_if   chars();
	adf_result_if results();

	ascii_decimal_to_fixed_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (chars),
		.dout   (results)
	);

	// Characters waiting to be sent, and results waiting to arrive
	char_item_t    pending_chars[$];
	fixed_result_t expected_fixed[$];

	// Model state of the converter
	logic [INT_W-1:0]  acc_int;
	logic [FRAC_W-1:0] acc_frac;
	logic [FCNT_W-1:0] frac_cnt;
	logic              got_point;
	logic              neg;
	logic              first_char;
	logic [ST_W-1:0]   err;

	int n_mismatch;
	int n_strings;
	int n_taken;
	int n_predicted;
	int n_checked;
	int idle_cycles;
	int status_seen[4];
	int stall_left;
	logic stall_done;

	// Flip the clock every half period
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		n_mismatch++;
	endtask

	task automatic clear_converter();
		acc_int    = '0;
		acc_frac   = '0;
		frac_cnt   = '0;
		got_point  = 1'b0;
		neg        = 1'b0;
		first_char = 1'b1;
		err        = ST_OK;
	endtask

	// Keep only the first error of a string
	task automatic note_error(input logic [ST_W-1:0] code);
		if (err == ST_OK) begin
			err = code;
		end
	endtask

	// Fold one character into the model; on the last one queue the expected result
	task automatic convert_char(input logic [CHAR_W-1:0] c, input logic last);
		logic        first;
		logic [63:0] grown;
		logic [63:0] scale;
		logic [63:0] frac_scaled;
		logic [63:0] mag;
		logic [63:0] max_int;
		logic [63:0] max_out;
		logic [63:0] signed_mag;
		int          i;
		fixed_result_t res;
		first = first_char;
		first_char = 1'b0;
		if (first && (c == CH_PLUS || c == CH_MINUS)) begin
			neg = (c == CH_MINUS);
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			if (!got_point) begin
				grown = 64'(acc_int) * 64'd10 + 64'(c - CH_ZERO);
				if (grown > 64'(INT_MAX_MAG)) begin
					grown = 64'(INT_MAX_MAG);
					note_error(ST_INT_SAT);
				end
				acc_int = grown[INT_W-1:0];
			end else if (frac_cnt < MAX_FRAC_DIGITS) begin
				acc_frac = FRAC_W'(acc_frac * 10 + FRAC_W'(c - CH_ZERO));
				frac_cnt = frac_cnt + 1'b1;
			end else begin
				note_error(ST_FRAC_OVF);
			end
		end else if (c == CH_POINT) begin
			if (got_point) begin
				note_error(ST_BAD_CHAR);
			end else begin
				got_point = 1'b1;
			end
		end else begin
			note_error(ST_BAD_CHAR);
		end
		if (!last) begin
			return;
		end

		// Divide the fraction digits by ten to the count, truncated
		scale = 64'd1;
		for (i = 0; i < frac_cnt && i < 9; i++) begin
			scale = scale * 64'd10;
		end
		frac_scaled = (64'(acc_frac) << FRAC_BITS) / scale;

		// Join integer and fraction, saturate to the output range
		max_out = 64'(OUT_MAX_MAG);
		max_int = max_out >> FRAC_BITS;
		if (64'(acc_int) > max_int) begin
			mag = max_out;
			note_error(ST_INT_SAT);
		end else begin
			mag = (64'(acc_int) << FRAC_BITS) + frac_scaled;
			if (mag > max_out) begin
				mag = max_out;
				note_error(ST_INT_SAT);
			end
		end
		signed_mag = neg ? (64'd0 - mag) : mag;
		res.value  = signed_mag[OUT_W-1:0];
		res.status = err;
		expected_fixed.push_back(res);
		n_predicted++;
		clear_converter();
	endtask

	task automatic add_char(input logic [CHAR_W-1:0] c, input logic last,
			input logic drain);
		char_item_t it;
		it.code  = c;
		it.last  = last;
		it.drain = drain;
		pending_chars.push_back(it);
	endtask

	task automatic add_text(input string s, input logic drain);
		int i;
		for (i = 0; i < s.len(); i++) begin
			add_char(s[i], i == s.len() - 1, drain && i == 0);
		end
		n_strings++;
	endtask

	// Build one random string: mostly well-formed numbers, some noise or broken ones
	task automatic add_random_string(input logic drain);
		logic [CHAR_W-1:0] body[$];
		int k;
		int n;
		int i;
		k = $urandom_range(0, 99);
		if (k < 5) begin
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++) begin
				body.push_back(CHAR_W'($urandom_range(0, 255)));
			end
		end else begin
			case ($urandom_range(0, 2))
				0: body.push_back(CH_PLUS);
				1: body.push_back(CH_MINUS);
				default: ;
			endcase
			n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(7, 12);
			for (i = 0; i < n; i++) begin
				body.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 99) < 75) begin
				body.push_back(CH_POINT);
				n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 9)
					: $urandom_range(10, 12);
				for (i = 0; i < n; i++) begin
					body.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
				end
			end
			if (body.size() == 0) begin
				body.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
			end
			// Break some strings: stray byte, second point, misplaced sign
			if (k < 20) begin
				body.insert($urandom_range(0, body.size()), CHAR_W'($urandom_range(0, 255)));
			end else if (k < 27) begin
				body.insert($urandom_range(0, body.size()), CH_POINT);
			end else if (k < 32) begin
				body.insert($urandom_range(1, body.size()),
					($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
			end
		end
		for (i = 0; i < body.size(); i++) begin
			add_char(body[i], i == body.size() - 1, drain && i == 0);
		end
		n_strings++;
	endtask

	// Drive characters; a drain item waits until every result is back
	always @(posedge clk or negedge arst_n) begin : drive_chars
		char_item_t nxt;
		logic took;
		logic calm;
		if (!arst_n) begin
			chars.valid     <= 1'b0;
			chars.char_code <= '0;
			chars.is_last   <= 1'b0;
		end else begin
			took = chars.valid && chars.ready;
			if (took) begin
				convert_char(chars.char_code, chars.is_last);
				n_taken++;
			end
			calm = (n_taken >= 700 && n_taken < 1000);
			if (chars.valid && !took) begin
				// hold the item until it is taken
			end else if (pending_chars.size() != 0 &&
					(!pending_chars[0].drain || n_predicted == n_checked) &&
					(calm || $urandom_range(0, 99) >= 10)) begin
				nxt = pending_chars.pop_front();
				chars.valid     <= 1'b1;
				chars.char_code <= nxt.code;
				chars.is_last   <= nxt.last;
			end else begin
				chars.valid <= 1'b0;
			end
		end
	end

	// Check results in order and throttle ready, with one long hold-off
	always @(posedge clk or negedge arst_n) begin : check_results
		fixed_result_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
			n_checked     <= 0;
			stall_left    <= 0;
			stall_done    <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_fixed.size() == 0) begin
					report_mismatch($sformatf("result value %0d status %0d with nothing expected",
						results.value, results.status));
				end else begin
					want = expected_fixed.pop_front();
					if (results.value !== want.value) begin
						report_mismatch($sformatf("result %0d: value %0d, want %0d",
							n_checked, results.value, want.value));
					end
					if (results.status !== want.status) begin
						report_mismatch($sformatf("result %0d: status %0d, want %0d",
							n_checked, results.status, want.status));
					end
				end
				status_seen[results.status]++;
				n_checked <= n_checked + 1;
			end
			if (stall_left != 0) begin
				results.ready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else if (!stall_done && n_checked == 40) begin
				results.ready <= 1'b0;
				stall_left    <= RX_HOLD;
				stall_done    <= 1'b1;
			end else begin
				results.ready <= (n_checked >= 90 && n_checked < 130) ||
					($urandom_range(0, 99) >= 10);
			end
		end
	end

	// Count cycles without any handshake
	always @(posedge clk) begin
		if ((chars.valid && chars.ready) || (results.valid && results.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : run
		int i;
		clk             = 1'b0;
		arst_n          = 1'b0;
		chars.valid     = 1'b0;
		chars.char_code = '0;
		chars.is_last   = 1'b0;
		results.ready   = 1'b0;
		idle_cycles     = 0;
		n_mismatch      = 0;
		n_strings       = 0;
		n_taken         = 0;
		n_predicted     = 0;
		for (i = 0; i < 4; i++) begin
			status_seen[i] = 0;
		end
		clear_converter();

		// Directed strings: sign on a zero integer, sign only, lone point, byte extremes,
		// second point, misplaced sign, integer saturation, excess fraction digits
		// followed by a bad character (first error sticks)
		add_text("-0.5", 1'b0);
		add_char(CH_MINUS, 1'b1, 1'b0);
		n_strings++;
		add_text(".", 1'b0);
		add_char(8'h00, 1'b1, 1'b0);
		add_char(8'hFF, 1'b1, 1'b0);
		n_strings += 2;
		add_text("1.2.3", 1'b1);
		add_text("5-", 1'b0);
		add_text("2147483648", 1'b0);
		add_text(".0000000001a", 1'b0);

		// Random strings, pausing for a full drain now and then
		i = 0;
		while (pending_chars.size() < TARGET_CHARS) begin
			add_random_string(i % 25 == 0);
			i++;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sample completion away from the active edge
		while (!(pending_chars.size() == 0 && !chars.valid && expected_fixed.size() == 0)
				&& idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
		end

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, expected_fixed.size());
			$display("[FAIL] regression broken");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (expected_fixed.size() != 0) begin
				report_mismatch($sformatf("%0d results never arrived", expected_fixed.size()));
			end
			$display("sent %0d characters in %0d strings, checked %0d results",
				n_taken, n_strings, n_checked);
			$display("status mix: ok %0d, bad char %0d, int saturated %0d, frac overflow %0d",
				status_seen[ST_OK], status_seen[ST_BAD_CHAR], status_seen[ST_INT_SAT],
				status_seen[ST_FRAC_OVF]);
			if (n_mismatch == 0) begin
				$display("[ OK ] regression clean");
			end else begin
				$display("[FAIL] regression broken");
			end
		end
		$finish;
	end

endmodule
